/* design/eta_pkg.sv */
// ----------------------------------------------------------------------------
// eta_pkg
// Shared types, widths, register codes and saturation helpers for the
// eased tween animator.
// ----------------------------------------------------------------------------
package eta_pkg;

	// elapsed counter width
	localparam int TIME_BITS = 16;
	// fraction is unsigned Q0.16, one extra bit so that 1.0 is exact
	localparam int FRAC_BITS = 16;
	localparam int Q_BITS    = FRAC_BITS + 1;
	localparam int CNT_W     = $clog2(Q_BITS + 1);

	// shared multiplier operand and product widths
	localparam int MUL_A_W = 19;
	localparam int MUL_B_W = 18;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_DURATION   = 3'd0,
		REG_EASING     = 3'd1,
		REG_BACK_SPEED = 3'd2,
		REG_ANIM_MODE  = 3'd3,
		REG_START      = 3'd4,
		REG_END        = 3'd5,
		REG_SLIDE_PIX  = 3'd6,
		REG_SLIDE_FADE = 3'd7
	} cfg_reg_t;

	// easing codes
	localparam logic [1:0] EASE_LINEAR = 2'd0;
	localparam logic [1:0] EASE_OUT    = 2'd1;
	localparam logic [1:0] EASE_IN     = 2'd2;

	// animation kinds
	localparam logic [2:0] MODE_FADE        = 3'd0;
	localparam logic [2:0] MODE_SCALE       = 3'd1;
	localparam logic [2:0] MODE_SLIDE_LEFT  = 3'd2;
	localparam logic [2:0] MODE_SLIDE_RIGHT = 3'd3;
	localparam logic [2:0] MODE_SLIDE_UP    = 3'd4;
	localparam logic [2:0] MODE_SLIDE_DOWN  = 3'd5;

	// divider request
	typedef struct packed {
		logic                 start;
		logic [TIME_BITS-1:0] num;
		logic [15:0]          den;
	} div_req_t;

	function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
		logic signed [15:0] r;
		if (v > 36'sd32767) r = 16'sh7fff;
		else if (v < -36'sd32768) r = 16'sh8000;
		else r = v[15:0];
		return r;
	endfunction

	function automatic logic signed [23:0] sat24(input logic signed [35:0] v);
		logic signed [23:0] r;
		if (v > 36'sd8388607) r = 24'sh7fffff;
		else if (v < -36'sd8388608) r = 24'sh800000;
		else r = v[23:0];
		return r;
	endfunction

endpackage

/* design/eta_divider.sv */
// ----------------------------------------------------------------------------
// eta_divider
// Restoring divider, one quotient bit per cycle: (num << 16) / den for
// num <= den, giving an unsigned Q0.16 fraction with 1.0 exact.
// ----------------------------------------------------------------------------
module eta_divider
	import eta_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  div_req_t          req,
	output logic              done,
	output logic [Q_BITS-1:0] quot
);

	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic [Q_BITS-1:0] rem_q;
	logic [Q_BITS-1:0] quot_q;
	logic [15:0]       den_q;

	logic              ge;
	logic [Q_BITS-1:0] rem_sub;
	logic [Q_BITS-1:0] rem_keep;

	always_comb begin
		ge       = rem_q >= {1'b0, den_q};
		rem_sub  = rem_q - {1'b0, den_q};
		rem_keep = ge ? rem_sub : rem_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (req.start) begin
			cnt_q  <= CNT_W'(Q_BITS);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= {1'b0, req.num};
			den_q  <= req.den;
			quot_q <= '0;
		end else if (cnt_q != '0) begin
			quot_q <= {quot_q[Q_BITS-2:0], ge};
			rem_q  <= {rem_keep[Q_BITS-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

/* design/eta_mul.sv */
// ----------------------------------------------------------------------------
// eta_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module eta_mul
	import eta_pkg::*;
(
	input  logic                      clk,
	input  logic signed [MUL_A_W-1:0] a,
	input  logic signed [MUL_B_W-1:0] b,
	output logic signed [MUL_P_W-1:0] prod
);

	logic signed [MUL_P_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= MUL_P_W'(a) * MUL_P_W'(b);
	end

	assign prod = prod_q;

endmodule

/* design/eased_tween_animator_unit.sv */
// ----------------------------------------------------------------------------
// eased_tween_animator_unit
// Tick-driven tween animator: advances or rewinds an elapsed counter, forms
// the Q0.16 fraction elapsed/duration, shapes it by an easing curve and
// drives a fade, a scale (with parent centering) or a one-axis slide.
// ----------------------------------------------------------------------------
//
//  channel | signals                                   | beat moves
//  --------+-------------------------------------------+---------------------
//  cfg     | cfg_we, cfg_index, cfg_data               | one register write
//  in      | in_valid/in_ready, delta_ms .. parent_*   | one time tick
//  out     | out_valid/out_ready, alpha_out .. active  | one tween result
//
// A tick runs through the 17-step restoring divider and passes through the
// one shared 19x18 multiplier under the sequencer; unused modes take the
// fewest passes and scale with a parent the most.
// Reset (arst_n low) restores the register defaults, clears elapsed time and
// sets alpha and scale to 1.0; there is no clearing pass.
// The result sits in an output register, so in_ready returns as soon as the
// result is loaded, even while out_ready holds it stalled.
// ----------------------------------------------------------------------------
module eased_tween_animator_unit
	import eta_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	// tick input
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [15:0]        delta_ms,
	input  logic               backward,
	input  logic               parent_present,
	input  logic [11:0]        parent_width,
	input  logic [11:0]        parent_height,
	// result output
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] alpha_out,
	output logic signed [15:0] scale_out,
	output logic signed [23:0] offset_x_out,
	output logic signed [23:0] offset_y_out,
	output logic               active
);

	// sequencer states, one-hot
	typedef enum logic [14:0] {
		S_IDLE   = 15'b000000000000001,
		S_TIME   = 15'b000000000000010, // delta * back_speed
		S_CLAMP  = 15'b000000000000100, // update elapsed, start divide
		S_DIV    = 15'b000000000001000,
		S_EASE   = 15'b000000000010000, // easing product
		S_MSEL   = 15'b000000000100000, // pick eased fraction, dispatch
		S_LERP   = 15'b000000001000000, // (end - start) * m
		S_LERPW  = 15'b000000010000000,
		S_OFFX   = 15'b000000100000000, // width * (256 - scale)
		S_OFFY   = 15'b000001000000000, // write x, height * (256 - scale)
		S_OFFW   = 15'b000010000000000, // write y
		S_SLIDE  = 15'b000100000000000, // (1 - m) * amount
		S_SLIDEW = 15'b001000000000000, // write axis, m * m
		S_FADEW  = 15'b010000000000000, // optional slide alpha
		S_OUT    = 15'b100000000000000
	} state_t;

	state_t state_q, state_d;

	// configuration registers
	logic [15:0]        duration_q;
	logic [1:0]         easing_q;
	logic [11:0]        back_speed_q;
	logic [2:0]         anim_mode_q;
	logic signed [15:0] start_q;
	logic signed [15:0] end_q;
	logic signed [12:0] slide_pix_q;
	logic               slide_fades_q;

	// animation state
	logic [TIME_BITS-1:0] elapsed_q;
	logic signed [15:0]   alpha_q;
	logic signed [15:0]   scale_q;
	logic signed [23:0]   offset_x_q;
	logic signed [23:0]   offset_y_q;

	// captured tick
	logic [15:0] delta_q;
	logic        backward_q;
	logic        parent_q;
	logic [11:0] pw_q;
	logic [11:0] ph_q;

	logic              active_q;
	logic [Q_BITS-1:0] m_q;

	// output register
	logic               out_valid_q;
	logic signed [15:0] alpha_o_q;
	logic signed [15:0] scale_o_q;
	logic signed [23:0] offx_o_q;
	logic signed [23:0] offy_o_q;
	logic               active_o_q;

	// shared units
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] prod;
	div_req_t                  div_req;
	logic                      div_done;
	logic [Q_BITS-1:0]         div_quot;

	// combinational helpers
	logic [19:0]          rewind;
	logic [15:0]          raw_back;
	logic [16:0]          raw_time;
	logic [TIME_BITS-1:0] elapsed_d;
	logic signed [16:0]   span;
	logic signed [16:0]   shrink;
	logic signed [13:0]   slide_amt;
	logic [Q_BITS-1:0]    m_rest;
	logic [17:0]          m_out_fac;
	logic                 in_beat;
	logic                 out_load;
	logic                 is_slide;

	assign in_beat  = in_valid && in_ready;
	assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready);
	assign is_slide = (anim_mode_q == MODE_SLIDE_LEFT) || (anim_mode_q == MODE_SLIDE_RIGHT) ||
		(anim_mode_q == MODE_SLIDE_UP) || (anim_mode_q == MODE_SLIDE_DOWN);

	// ------------------------------------------------------------------
	// elapsed update: advance by delta, or rewind by delta*speed (Q4.8),
	// then clamp into [0, duration]
	// ------------------------------------------------------------------
	always_comb begin
		rewind    = prod[27:8];
		raw_back  = (rewind > {4'b0, elapsed_q}) ? '0 : elapsed_q - rewind[15:0];
		raw_time  = backward_q ? {1'b0, raw_back} : ({1'b0, elapsed_q} + {1'b0, delta_q});
		elapsed_d = (raw_time > {1'b0, duration_q}) ? duration_q : raw_time[15:0];
	end

	// operand helpers
	always_comb begin
		span      = 17'(end_q) - 17'(start_q);
		shrink    = 17'sd256 - 17'(scale_q);
		// plus for left and up, minus for right and down
		slide_amt = ((anim_mode_q == MODE_SLIDE_LEFT) || (anim_mode_q == MODE_SLIDE_UP)) ?
			14'(slide_pix_q) : -14'(slide_pix_q);
		m_rest    = Q_BITS'(17'h10000) - m_q;
		m_out_fac = 18'h20000 - {1'b0, m_q};
	end

	// ------------------------------------------------------------------
	// multiplier operand select, product lands in the next cycle
	// ------------------------------------------------------------------
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_TIME: begin
				mul_a = MUL_A_W'({1'b0, delta_q});
				mul_b = MUL_B_W'({1'b0, back_speed_q});
			end
			S_EASE: begin
				mul_a = (easing_q == EASE_OUT) ? MUL_A_W'({1'b0, m_out_fac}) :
					MUL_A_W'({1'b0, m_q});
				mul_b = MUL_B_W'({1'b0, m_q});
			end
			S_LERP: begin
				mul_a = MUL_A_W'(span);
				mul_b = MUL_B_W'({1'b0, m_q});
			end
			S_OFFX: begin
				mul_a = MUL_A_W'({1'b0, pw_q});
				mul_b = MUL_B_W'(shrink);
			end
			S_OFFY: begin
				mul_a = MUL_A_W'({1'b0, ph_q});
				mul_b = MUL_B_W'(shrink);
			end
			S_SLIDE: begin
				mul_a = MUL_A_W'(slide_amt);
				mul_b = MUL_B_W'({1'b0, m_rest});
			end
			S_SLIDEW: begin
				mul_a = MUL_A_W'({1'b0, m_q});
				mul_b = MUL_B_W'({1'b0, m_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	eta_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	always_comb begin
		div_req.start = (state_q == S_CLAMP);
		div_req.num   = elapsed_d;
		div_req.den   = duration_q;
	end

	eta_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quot   (div_quot)
	);

	// ------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (in_valid) state_d = S_TIME;
			S_TIME:   state_d = S_CLAMP;
			S_CLAMP:  state_d = S_DIV;
			S_DIV:    if (div_done) state_d = S_EASE;
			S_EASE:   state_d = S_MSEL;
			S_MSEL: begin
				if ((anim_mode_q == MODE_FADE) || (anim_mode_q == MODE_SCALE)) begin
					state_d = S_LERP;
				end else if (is_slide) begin
					state_d = S_SLIDE;
				end else begin
					state_d = S_OUT;
				end
			end
			S_LERP:   state_d = S_LERPW;
			S_LERPW: begin
				// center only a scale that has a parent; otherwise offsets hold
				if ((anim_mode_q == MODE_SCALE) && parent_q) state_d = S_OFFX;
				else state_d = S_OUT;
			end
			S_OFFX:   state_d = S_OFFY;
			S_OFFY:   state_d = S_OFFW;
			S_OFFW:   state_d = S_OUT;
			S_SLIDE:  state_d = S_SLIDEW;
			S_SLIDEW: state_d = S_FADEW;
			S_FADEW:  state_d = S_OUT;
			S_OUT:    if (out_load) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	// ------------------------------------------------------------------
	// configuration: zero duration and zero speed writes are dropped
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duration_q    <= 16'd1000;
			easing_q      <= EASE_LINEAR;
			back_speed_q  <= 12'd256;
			anim_mode_q   <= MODE_FADE;
			start_q       <= 16'sd0;
			end_q         <= 16'sd256;
			slide_pix_q   <= 13'sd0;
			slide_fades_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_DURATION:   if (cfg_data != '0) duration_q <= cfg_data;
				REG_EASING:     easing_q <= cfg_data[1:0];
				REG_BACK_SPEED: if (cfg_data[11:0] != '0) back_speed_q <= cfg_data[11:0];
				REG_ANIM_MODE:  anim_mode_q <= cfg_data[2:0];
				REG_START:      start_q <= cfg_data;
				REG_END:        end_q <= cfg_data;
				REG_SLIDE_PIX:  slide_pix_q <= cfg_data[12:0];
				REG_SLIDE_FADE: slide_fades_q <= cfg_data[0];
				default:        ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// animation state, written by the sequencer steps
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q  <= '0;
			alpha_q    <= 16'sd256;
			scale_q    <= 16'sd256;
			offset_x_q <= '0;
			offset_y_q <= '0;
		end else begin
			unique case (state_q)
				S_CLAMP: elapsed_q <= elapsed_d;
				S_LERPW: begin
					if (anim_mode_q == MODE_FADE) begin
						alpha_q <= sat16(36'($signed(prod[36:16])) + 36'(start_q));
					end else begin
						scale_q <= sat16(36'($signed(prod[36:16])) + 36'(start_q));
					end
				end
				S_OFFY: offset_x_q <= sat24($signed(prod[36:1]));
				S_OFFW: offset_y_q <= sat24($signed(prod[36:1]));
				S_SLIDEW: begin
					if ((anim_mode_q == MODE_SLIDE_LEFT) || (anim_mode_q == MODE_SLIDE_RIGHT)) begin
						offset_x_q <= sat24(36'($signed(prod[36:8])));
						offset_y_q <= '0;
					end else begin
						offset_x_q <= '0;
						offset_y_q <= sat24(36'($signed(prod[36:8])));
					end
				end
				// m*m / 2^24 is at most 256, no clipping needed
				S_FADEW: if (slide_fades_q) alpha_q <= {3'b0, prod[36:24]};
				default: ;
			endcase
		end
	end

	// tick capture and working fraction, no reset
	always_ff @(posedge clk) begin
		if (in_beat) begin
			delta_q    <= delta_ms;
			backward_q <= backward;
			parent_q   <= parent_present;
			pw_q       <= parent_width;
			ph_q       <= parent_height;
		end
		if (state_q == S_CLAMP) begin
			active_q <= backward_q ? (elapsed_d != '0) : (elapsed_d < duration_q);
		end
		if ((state_q == S_DIV) && div_done) begin
			m_q <= div_quot;
		end
		// ease out and ease in take the upper half of the product
		if ((state_q == S_MSEL) && ((easing_q == EASE_OUT) || (easing_q == EASE_IN))) begin
			m_q <= prod[32:16];
		end
	end

	// ------------------------------------------------------------------
	// output register: load in S_OUT, hold while stalled
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			alpha_o_q  <= alpha_q;
			scale_o_q  <= scale_q;
			offx_o_q   <= offset_x_q;
			offy_o_q   <= offset_y_q;
			active_o_q <= active_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign alpha_out    = alpha_o_q;
	assign scale_out    = scale_o_q;
	assign offset_x_out = offx_o_q;
	assign offset_y_out = offy_o_q;
	assign active       = active_o_q;

endmodule

/* design/eta_checker.sv */
// ----------------------------------------------------------------------------
// eta_checker
// Port-level checks for the eased tween animator, bound to the top level.
// ----------------------------------------------------------------------------
module eta_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [15:0] alpha_out,
	input logic signed [15:0] scale_out,
	input logic signed [23:0] offset_x_out,
	input logic signed [23:0] offset_y_out,
	input logic               active
);

	// a tick keeps the block busy, so in_ready does not return straight after its beat
	a_busy_after_tick: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready)
		else $error("in_ready returned too soon after a tick beat");

	// a fresh result appears exactly as the block returns to ready
	a_ready_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result appeared while the block was still busy");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out_valid dropped before its beat");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(alpha_out) && $stable(scale_out) &&
		$stable(offset_x_out) && $stable(offset_y_out) && $stable(active))
		else $error("stalled result changed");

endmodule

bind eased_tween_animator_unit eta_checker u_eta_checker (.*);
